// ===== hdl/rsnp_pkg.sv =====
// Shared types, record codes and suite tables of the RSN element parser.
// No dependencies.
package rsnp_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);
  localparam int unsigned MaxRecs    = 3;

  localparam logic [3:0] KindSsid    = 4'd0;
  localparam logic [3:0] KindVersion = 4'd1;
  localparam logic [3:0] KindGroup   = 4'd2;
  localparam logic [3:0] KindPair    = 4'd3;
  localparam logic [3:0] KindAkm     = 4'd4;
  localparam logic [3:0] KindCaps    = 4'd5;
  localparam logic [3:0] KindPmkCnt  = 4'd6;
  localparam logic [3:0] KindMgmt    = 4'd7;
  localparam logic [3:0] KindTail    = 4'd8;
  localparam logic [3:0] KindInvalid = 4'd9;

  localparam logic [1:0] OuiMs    = 2'd0;
  localparam logic [1:0] OuiIeee  = 2'd1;
  localparam logic [1:0] OuiWfa   = 2'd2;
  localparam logic [1:0] OuiOther = 2'd3;

  localparam logic [7:0] SuiteCcmp  = 8'd4;
  localparam logic [7:0] Suite8021x = 8'd1;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] value;
    logic [1:0]  oui;
    logic [7:0]  stype;
    logic        known;
    logic        dflt;
  } rec_t;

  typedef struct packed {
    logic [1:0] count;
    rec_t [MaxRecs-1:0] recs;
  } bundle_t;

  function automatic logic [1:0] oui_of(input logic [23:0] h);
    case (h)
      24'h0050f2: oui_of = OuiMs;
      24'h000fac: oui_of = OuiIeee;
      24'h506f9a: oui_of = OuiWfa;
      default:    oui_of = OuiOther;
    endcase
  endfunction

  function automatic logic cipher_known(input logic [1:0] oui, input logic [7:0] t);
    if (oui == OuiMs) cipher_known = (t inside {8'd0, 8'd1, 8'd2, 8'd4, 8'd5});
    else if (oui == OuiIeee) cipher_known = (t <= 8'd8) && (t != 8'd3);
    else cipher_known = 1'b0;
  endfunction

  function automatic logic akm_known(input logic [1:0] oui, input logic [7:0] t);
    if (oui == OuiMs || oui == OuiWfa) akm_known = (t inside {8'd1, 8'd2});
    else if (oui == OuiIeee) akm_known = (t inside {[8'd1:8'd18]}) && (t != 8'd10);
    else akm_known = 1'b0;
  endfunction

  function automatic rec_t mk_rec(input logic [3:0] kind, input logic [15:0] value);
    rec_t r;
    r = '0;
    r.kind  = kind;
    r.value = value;
    return r;
  endfunction

  function automatic rec_t mk_default(input logic [3:0] kind, input logic [7:0] t);
    rec_t r;
    r = '0;
    r.kind  = kind;
    r.oui   = OuiIeee;
    r.stype = t;
    r.known = 1'b1;
    r.dflt  = 1'b1;
    return r;
  endfunction

  function automatic rec_t mk_suite(input logic [3:0] kind, input logic [23:0] held,
                                    input logic [7:0] t);
    rec_t r;
    r = '0;
    r.kind  = kind;
    r.oui   = oui_of(held);
    r.stype = t;
    r.known = (kind == KindAkm) ? akm_known(r.oui, t) : cipher_known(r.oui, t);
    return r;
  endfunction

endpackage

// ===== hdl/rsnp_in_if.sv =====
// Input byte channel of the RSN element parser.
// Depends on nothing.
interface rsnp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic [15:0] buffer_length;
  modport source(output valid, data_byte, first_byte, buffer_length, input ready);
  modport sink(input valid, data_byte, first_byte, buffer_length, output ready);
endinterface

// ===== hdl/rsnp_out_if.sv =====
// Record output channel of the RSN element parser.
// Depends on nothing.
interface rsnp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  record_kind;
  logic [15:0] record_value;
  logic [1:0]  oui_class;
  logic [7:0]  suite_type;
  logic        suite_known;
  logic        defaulted;
  logic        last_of_run;
  modport source(output valid, record_kind, record_value, oui_class, suite_type,
                 suite_known, defaulted, last_of_run, input ready);
  modport sink(input valid, record_kind, record_value, oui_class, suite_type,
               suite_known, defaulted, last_of_run, output ready);
endinterface

// ===== hdl/rsnp_front.sv =====
// Front end: accepts buffer bytes, walks the elements and builds record bundles.
// Depends on rsnp_pkg and rsnp_in_if.
module rsnp_front (
  input  logic              clk,
  input  logic              rst,
  rsnp_in_if.sink           in_ch,
  input  logic              q_full,
  output logic              push,
  output rsnp_pkg::bundle_t bundle
);
  import rsnp_pkg::*;

  typedef enum logic [3:0] {
    PH_TYPE, PH_LEN, PH_SKIP, PH_SSID, PH_VER, PH_GROUP, PH_PCOUNT, PH_PSUITE,
    PH_ACOUNT, PH_ASUITE, PH_CAPS, PH_PMKCNT, PH_PMKSKIP, PH_MGMT, PH_TAIL, PH_DONE
  } phase_t;

  localparam logic [1:0] EkOther = 2'd0;
  localparam logic [1:0] EkSsid  = 2'd1;
  localparam logic [1:0] EkRsn   = 2'd2;

  phase_t      phase, phase_next;
  logic [1:0]  ekind, ekind_next;
  logic [7:0]  ebl, ebl_next;
  logic [15:0] bbl, bbl_next;
  logic [7:0]  sil, sil_next;
  logic [1:0]  bif, bif_next;
  logic [23:0] held, held_next;

  logic        accept;
  logic [7:0]  b;
  logic [15:0] rem;
  logic [7:0]  left;
  logic [15:0] cnt;
  logic        takes, need4, done;
  logic [1:0]  n;
  rec_t        recs [MaxRecs];

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;

  always_comb begin
    phase_next = phase;
    ekind_next = ekind;
    ebl_next   = ebl;
    bbl_next   = bbl;
    sil_next   = sil;
    bif_next   = bif;
    held_next  = held;
    n          = 2'd0;
    for (int i = 0; i < MaxRecs; i++) recs[i] = '0;
    rem   = '0;
    left  = '0;
    cnt   = {b, held[7:0]};
    takes = 1'b0;
    need4 = 1'b0;
    done  = 1'b0;

    if (in_ch.first_byte) begin
      phase_next = PH_TYPE;
      ekind_next = EkOther;
      ebl_next   = '0;
      bbl_next   = in_ch.buffer_length;
      sil_next   = '0;
      bif_next   = '0;
      held_next  = '0;
    end

    if (bbl_next != 16'd0 && phase_next != PH_DONE) begin
      rem      = bbl_next;
      bbl_next = rem - 16'd1;
      if (phase_next == PH_TYPE) begin
        if (rem < 16'd2) phase_next = PH_DONE;
        else begin
          ekind_next = (b == 8'd0) ? EkSsid : (b == 8'd48) ? EkRsn : EkOther;
          phase_next = PH_LEN;
        end
      end else if (phase_next == PH_LEN) begin
        if (bbl_next < {8'd0, b}) phase_next = PH_DONE;
        else begin
          ebl_next   = b;
          bif_next   = '0;
          held_next  = '0;
          phase_next = PH_SKIP;
          if (ekind_next == EkSsid) begin
            if (b > 8'd32) begin
              recs[0] = mk_rec(KindInvalid, {8'd0, b});
              n = 2'd1;
            end else phase_next = PH_SSID;
          end else if (ekind_next == EkRsn) begin
            if (b < 8'd2) begin
              recs[0] = mk_rec(KindInvalid, {8'd0, b});
              n = 2'd1;
            end else phase_next = PH_VER;
          end
          if (b == 8'd0) phase_next = PH_TYPE;
        end
      end else begin
        ebl_next = ebl_next - 8'd1;
        left     = ebl_next;
        // collect multi-byte fields; done marks the closing byte
        takes = phase_next inside {PH_VER, PH_GROUP, PH_PCOUNT, PH_ACOUNT, PH_PSUITE,
                                   PH_ASUITE, PH_CAPS, PH_PMKCNT, PH_MGMT};
        need4 = phase_next inside {PH_GROUP, PH_PSUITE, PH_ASUITE, PH_MGMT};
        done  = need4 ? (bif == 2'd3) : (bif != 2'd0);
        if (takes) begin
          if (!done) begin
            held_next = {held[15:0], b};
            bif_next  = bif + 2'd1;
          end else bif_next = '0;
        end
        case (phase_next)
          PH_SSID: begin
            recs[0] = mk_rec(KindSsid, {8'd0, b});
            n = 2'd1;
          end
          PH_VER: if (done) begin
            recs[0] = mk_rec(KindVersion, cnt);
            n = 2'd1;
            if (left < 8'd4) begin
              recs[1] = mk_default(KindGroup, SuiteCcmp);
              recs[2] = mk_default(KindPair, SuiteCcmp);
              n = 2'd3;
              phase_next = PH_SKIP;
            end else phase_next = PH_GROUP;
          end
          PH_GROUP: if (done) begin
            recs[0] = mk_suite(KindGroup, held, b);
            n = 2'd1;
            if (left < 8'd2) begin
              recs[1] = mk_default(KindPair, SuiteCcmp);
              n = 2'd2;
              phase_next = PH_SKIP;
            end else phase_next = PH_PCOUNT;
          end
          PH_PCOUNT, PH_ACOUNT: if (done) begin
            if (cnt > {10'd0, left[7:2]}) begin
              recs[0] = mk_rec(KindTail, {8'd0, held[7:0]});
              recs[1] = mk_rec(KindTail, {8'd0, b});
              n = 2'd2;
              phase_next = PH_TAIL;
            end else begin
              sil_next = cnt[7:0];
              if (phase_next == PH_PCOUNT) begin
                if (cnt == 16'd0) begin
                  if (left < 8'd2) begin
                    recs[0] = mk_default(KindAkm, Suite8021x);
                    n = 2'd1;
                    phase_next = PH_SKIP;
                  end else phase_next = PH_ACOUNT;
                end else phase_next = PH_PSUITE;
              end else begin
                if (cnt == 16'd0) phase_next = (left >= 8'd2) ? PH_CAPS : PH_TAIL;
                else phase_next = PH_ASUITE;
              end
            end
          end
          PH_PSUITE: if (done) begin
            recs[0] = mk_suite(KindPair, held, b);
            n = 2'd1;
            sil_next = sil - 8'd1;
            if (sil_next == 8'd0) begin
              if (left < 8'd2) begin
                recs[1] = mk_default(KindAkm, Suite8021x);
                n = 2'd2;
                phase_next = PH_SKIP;
              end else phase_next = PH_ACOUNT;
            end
          end
          PH_ASUITE: if (done) begin
            recs[0] = mk_suite(KindAkm, held, b);
            n = 2'd1;
            sil_next = sil - 8'd1;
            if (sil_next == 8'd0) phase_next = (left >= 8'd2) ? PH_CAPS : PH_TAIL;
          end
          PH_CAPS: if (done) begin
            recs[0] = mk_rec(KindCaps, cnt);
            n = 2'd1;
            phase_next = (left >= 8'd2) ? PH_PMKCNT : PH_TAIL;
          end
          PH_PMKCNT: if (done) begin
            if (cnt > {12'd0, left[7:4]}) begin
              recs[0] = mk_rec(KindTail, {8'd0, held[7:0]});
              recs[1] = mk_rec(KindTail, {8'd0, b});
              n = 2'd2;
              phase_next = PH_TAIL;
            end else begin
              recs[0] = mk_rec(KindPmkCnt, cnt);
              n = 2'd1;
              // count is at most 15 here, so 16 * count fits in 8 bits
              sil_next = {cnt[3:0], 4'd0};
              if (cnt == 16'd0) phase_next = (left >= 8'd4) ? PH_MGMT : PH_TAIL;
              else phase_next = PH_PMKSKIP;
            end
          end
          PH_PMKSKIP: begin
            sil_next = sil - 8'd1;
            if (sil_next == 8'd0) phase_next = (left >= 8'd4) ? PH_MGMT : PH_TAIL;
          end
          PH_MGMT: if (done) begin
            recs[0] = mk_suite(KindMgmt, held, b);
            n = 2'd1;
            phase_next = PH_TAIL;
          end
          PH_TAIL: begin
            recs[0] = mk_rec(KindTail, {8'd0, b});
            n = 2'd1;
          end
          default: ;
        endcase
        if (ebl_next == 8'd0) begin
          phase_next = PH_TYPE;
          bif_next   = '0;
        end
      end
    end
  end

  assign push         = accept && (n != 2'd0);
  assign bundle.count = n;
  always_comb begin
    for (int i = 0; i < MaxRecs; i++) bundle.recs[i] = recs[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TYPE;
      ekind <= EkOther;
      ebl   <= '0;
      bbl   <= '0;
      sil   <= '0;
      bif   <= '0;
      held  <= '0;
    end else if (accept) begin
      phase <= phase_next;
      ekind <= ekind_next;
      ebl   <= ebl_next;
      bbl   <= bbl_next;
      sil   <= sil_next;
      bif   <= bif_next;
      held  <= held_next;
    end
  end

endmodule

// ===== hdl/rsnp_queue.sv =====
// Short bundle queue between the parser front end and the record back end.
// Depends on rsnp_pkg.
module rsnp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rsnp_pkg::bundle_t wr_bundle,
  input  logic              pop,
  output logic              full,
  output logic              nonempty,
  output rsnp_pkg::bundle_t head
);
  import rsnp_pkg::*;

  bundle_t           slots [QueueDepth];
  logic [QueueAw-1:0] wr_ptr, rd_ptr;
  logic [QueueAw:0]   fill;

  assign full     = (fill == (QueueAw+1)'(QueueDepth));
  assign nonempty = (fill != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_bundle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hdl/rsnp_back.sv =====
// Back end: sends the records of each queued bundle one per transfer.
// Depends on rsnp_pkg and rsnp_out_if.
module rsnp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              nonempty,
  input  rsnp_pkg::bundle_t head,
  output logic              pop,
  rsnp_out_if.source        out_ch
);
  import rsnp_pkg::*;

  logic       valid;
  logic [1:0] idx;
  logic       load, last;
  rec_t       rec, cur;
  logic       cur_last;

  assign load = nonempty && (!valid || out_ch.ready);
  assign last = (idx + 2'd1 == head.count);
  assign pop  = load && last;
  assign rec  = head.recs[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else begin
      if (load) begin
        valid <= 1'b1;
        idx   <= last ? 2'd0 : idx + 2'd1;
      end else if (out_ch.ready) valid <= 1'b0;
    end
  end

  // hold payload until the transfer completes
  always_ff @(posedge clk) begin
    if (load) begin
      cur      <= rec;
      cur_last <= last;
    end
  end

  assign out_ch.valid        = valid;
  assign out_ch.record_kind  = cur.kind;
  assign out_ch.record_value = cur.value;
  assign out_ch.oui_class    = cur.oui;
  assign out_ch.suite_type   = cur.stype;
  assign out_ch.suite_known  = cur.known;
  assign out_ch.defaulted    = cur.dflt;
  assign out_ch.last_of_run  = cur_last;

endmodule

// ===== hdl/wifi_rsn_element_parser_core.sv =====
// Channel   Dir  Payload
// in_ch     in   data_byte, first_byte, buffer_length
// out_ch    out  record_kind, record_value, oui_class, suite_type, suite_known,
//                defaulted, last_of_run
// One byte is taken per cycle while the four-entry bundle queue has room.
// Each byte yields zero to three records; the back end sends one record
// per cycle while out_ch is ready, so sustained input rate is one byte per cycle
// when records per byte average one. Reset (rst, synchronous) empties the queue
// and returns the walker to awaiting an element type.
// Depends on rsnp_pkg, rsnp_in_if, rsnp_out_if, rsnp_front, rsnp_queue, rsnp_back.
module wifi_rsn_element_parser_core (
  input  logic        clk,
  input  logic        rst,
  rsnp_in_if.sink     in_ch,
  rsnp_out_if.source  out_ch
);
  import rsnp_pkg::*;

  logic    push, pop, full, nonempty;
  bundle_t wr_bundle, head;

  rsnp_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch), .q_full(full), .push(push), .bundle(wr_bundle)
  );

  rsnp_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wr_bundle(wr_bundle), .pop(pop),
    .full(full), .nonempty(nonempty), .head(head)
  );

  rsnp_back u_back (
    .clk(clk), .rst(rst), .nonempty(nonempty), .head(head), .pop(pop), .out_ch(out_ch)
  );

endmodule
